[rtl/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV converter files.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CH_W    = 8;
	localparam int HUE_W   = 15;
	localparam int SAT_W   = 16;

	// Long division: numerator of NUM_W bits, quotient known to fit QUO_W bits
	localparam int NUM_W     = 24;
	localparam int QUO_W     = 16;
	localparam int STEP_BITS = 4;
	localparam int DIV_STEPS = QUO_W / STEP_BITS;

	localparam int HUE_CALC_W = 16;
	localparam logic signed [HUE_CALC_W-1:0] HUE_FULL_TURN    = 16'sd23040;
	localparam logic signed [HUE_CALC_W-1:0] HUE_GREEN_OFFSET = 16'sd7680;
	localparam logic signed [HUE_CALC_W-1:0] HUE_BLUE_OFFSET  = 16'sd15360;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

endpackage

[rtl/rgbhsv_pix_if.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pix_if
// Pixel request channel: one RGB pixel per request.
// ----------------------------------------------------------------------------
interface rgbhsv_pix_if;

	logic                         valid;
	logic                         ready;
	logic [rgbhsv_pkg::CH_W-1:0]  red;
	logic [rgbhsv_pkg::CH_W-1:0]  green;
	logic [rgbhsv_pkg::CH_W-1:0]  blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

[rtl/rgbhsv_hsv_if.sv]
// ----------------------------------------------------------------------------
// rgbhsv_hsv_if
// HSV result channel: hue, saturation and brightness per request.
// ----------------------------------------------------------------------------
interface rgbhsv_hsv_if;

	logic                          valid;
	logic                          ready;
	logic [rgbhsv_pkg::HUE_W-1:0]  hue;
	logic [rgbhsv_pkg::SAT_W-1:0]  saturation;
	logic [rgbhsv_pkg::CH_W-1:0]   brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);

endinterface

[rtl/rgbhsv_div_step.sv]
// ----------------------------------------------------------------------------
// rgbhsv_div_step
// Restoring long-division slice: retires STEP_BITS quotient bits against an
// 8-bit divisor. Partial remainder stays below the divisor.
// ----------------------------------------------------------------------------
module rgbhsv_div_step (
	input  logic [rgbhsv_pkg::CH_W-1:0]      rem_in,
	input  logic [rgbhsv_pkg::STEP_BITS-1:0] num_bits,
	input  logic [rgbhsv_pkg::CH_W-1:0]      den,
	output logic [rgbhsv_pkg::CH_W-1:0]      rem_out,
	output logic [rgbhsv_pkg::STEP_BITS-1:0] quo_bits
);

	always_comb begin
		logic [rgbhsv_pkg::CH_W-1:0] r;
		logic [rgbhsv_pkg::CH_W:0]   t;
		r = rem_in;
		quo_bits = '0;
		for (int i = rgbhsv_pkg::STEP_BITS - 1; i >= 0; i--) begin
			t = {r, num_bits[i]};
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				quo_bits[i] = 1'b1;
			end
			r = t[rgbhsv_pkg::CH_W-1:0];
		end
		rem_out = r;
	end

endmodule

[rtl/rgb_to_hsv_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV conversion: brightness = max, saturation =
// floor(diff*65535/max), hue in degrees * 64 from the sector of the max.
//
//   channel  modport  payload                               per request
//   pixel    sink     red[7:0] green[7:0] blue[7:0]         one pixel
//   hsv      source   hue[14:0] saturation[15:0] bright[7:0] one result
//
// Seven register stages: min/max, numerators, four long-division stages of
// four quotient bits each, hue fix-up into the output register.
// One pixel per clock sustained while hsv is ready.
// arst_n clears all stage valid bits; payload registers are not reset.
// Each stage advances when it is empty or the next one advances, so a stall
// on hsv fills bubbles first and then holds every stage in place.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	rgbhsv_pix_if.sink           pixel,
	rgbhsv_hsv_if.source         hsv
);

	localparam int S_DIV0 = 2;
	localparam int S_DIVN = S_DIV0 + rgbhsv_pkg::DIV_STEPS;
	localparam int S_OUT  = S_DIVN + 1;
	localparam int LOW_W  = rgbhsv_pkg::NUM_W - rgbhsv_pkg::CH_W;
	localparam int SB     = rgbhsv_pkg::STEP_BITS;

	logic [S_OUT:1] valid_s;
	logic [S_OUT:1] en;

	// stage 1
	logic [rgbhsv_pkg::CH_W-1:0] mx_c, mn_c, anum_c;
	logic                        neg_c;
	rgbhsv_pkg::sector_t         sec_c;

	logic [rgbhsv_pkg::CH_W-1:0] mx_s1, diff_s1, anum_s1;
	logic                        neg_s1;
	rgbhsv_pkg::sector_t         sec_s1;

	// stages 2..6
	logic [rgbhsv_pkg::CH_W-1:0]  bright_s   [S_DIV0:S_DIVN];
	logic                         neg_s      [S_DIV0:S_DIVN];
	rgbhsv_pkg::sector_t          sec_s      [S_DIV0:S_DIVN];
	logic [rgbhsv_pkg::CH_W-1:0]  sat_den_s  [S_DIV0:S_DIVN];
	logic [rgbhsv_pkg::CH_W-1:0]  sat_rem_s  [S_DIV0:S_DIVN];
	logic [LOW_W-1:0]             sat_low_s  [S_DIV0:S_DIVN];
	logic [rgbhsv_pkg::QUO_W-1:0] sat_quo_s  [S_DIV0:S_DIVN];
	logic [rgbhsv_pkg::CH_W-1:0]  hue_den_s  [S_DIV0:S_DIVN];
	logic [rgbhsv_pkg::CH_W-1:0]  hue_rem_s  [S_DIV0:S_DIVN];
	logic [LOW_W-1:0]             hue_low_s  [S_DIV0:S_DIVN];
	logic [rgbhsv_pkg::QUO_W-1:0] hue_quo_s  [S_DIV0:S_DIVN];

	logic [rgbhsv_pkg::NUM_W-1:0] sat_num_c, hue_num_c;

	// output stage
	logic signed [rgbhsv_pkg::HUE_CALC_W-1:0] hue_c;
	logic [rgbhsv_pkg::HUE_W-1:0] hue_s7;
	logic [rgbhsv_pkg::SAT_W-1:0] sat_s7;
	logic [rgbhsv_pkg::CH_W-1:0]  bright_s7;

	// ---------------- flow control ----------------
	always_comb begin
		en[S_OUT] = !valid_s[S_OUT] || hsv.ready;
		for (int k = S_OUT - 1; k >= 1; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	assign pixel.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[1]) begin
				valid_s[1] <= pixel.valid;
			end
			for (int k = 2; k <= S_OUT; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// ---------------- stage 1: max, min, sector ----------------
	always_comb begin
		mx_c = pixel.red;
		if (pixel.green > mx_c) mx_c = pixel.green;
		if (pixel.blue > mx_c)  mx_c = pixel.blue;
		mn_c = pixel.red;
		if (pixel.green < mn_c) mn_c = pixel.green;
		if (pixel.blue < mn_c)  mn_c = pixel.blue;

		if (mx_c == pixel.red)        sec_c = rgbhsv_pkg::SEC_RED;
		else if (mx_c == pixel.green) sec_c = rgbhsv_pkg::SEC_GREEN;
		else                          sec_c = rgbhsv_pkg::SEC_BLUE;

		case (sec_c)
			rgbhsv_pkg::SEC_GREEN: begin
				neg_c  = pixel.blue < pixel.red;
				anum_c = neg_c ? pixel.red - pixel.blue : pixel.blue - pixel.red;
			end
			rgbhsv_pkg::SEC_BLUE: begin
				neg_c  = pixel.red < pixel.green;
				anum_c = neg_c ? pixel.green - pixel.red : pixel.red - pixel.green;
			end
			default: begin
				neg_c  = pixel.green < pixel.blue;
				anum_c = neg_c ? pixel.blue - pixel.green : pixel.green - pixel.blue;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mx_s1   <= mx_c;
			diff_s1 <= mx_c - mn_c;
			anum_s1 <= anum_c;
			neg_s1  <= neg_c;
			sec_s1  <= sec_c;
		end
	end

	// ---------------- stage 2: numerators, divisors ----------------
	// diff*65535 and |num|*3840 by shift and subtract
	assign sat_num_c = {diff_s1, 16'd0} - {16'd0, diff_s1};
	assign hue_num_c = {4'd0, anum_s1, 12'd0} - {8'd0, anum_s1, 8'd0};

	always_ff @(posedge clk) begin
		if (en[S_DIV0]) begin
			bright_s[S_DIV0]  <= mx_s1;
			neg_s[S_DIV0]     <= neg_s1;
			sec_s[S_DIV0]     <= sec_s1;
			// zero divisor only with zero numerator; 1 keeps the quotient at zero
			sat_den_s[S_DIV0] <= (mx_s1 == '0) ? 8'd1 : mx_s1;
			hue_den_s[S_DIV0] <= (diff_s1 == '0) ? 8'd1 : diff_s1;
			sat_rem_s[S_DIV0] <= sat_num_c[rgbhsv_pkg::NUM_W-1:LOW_W];
			sat_low_s[S_DIV0] <= sat_num_c[LOW_W-1:0];
			sat_quo_s[S_DIV0] <= '0;
			hue_rem_s[S_DIV0] <= hue_num_c[rgbhsv_pkg::NUM_W-1:LOW_W];
			hue_low_s[S_DIV0] <= hue_num_c[LOW_W-1:0];
			hue_quo_s[S_DIV0] <= '0;
		end
	end

	// ---------------- stages 3..6: long division ----------------
	for (genvar k = S_DIV0 + 1; k <= S_DIVN; k++) begin : g_div
		logic [rgbhsv_pkg::CH_W-1:0] sat_rem_c, hue_rem_c;
		logic [SB-1:0]               sat_q_c, hue_q_c;

		rgbhsv_div_step u_sat_step (
			.rem_in   (sat_rem_s[k-1]),
			.num_bits (sat_low_s[k-1][LOW_W-1 -: SB]),
			.den      (sat_den_s[k-1]),
			.rem_out  (sat_rem_c),
			.quo_bits (sat_q_c)
		);

		rgbhsv_div_step u_hue_step (
			.rem_in   (hue_rem_s[k-1]),
			.num_bits (hue_low_s[k-1][LOW_W-1 -: SB]),
			.den      (hue_den_s[k-1]),
			.rem_out  (hue_rem_c),
			.quo_bits (hue_q_c)
		);

		always_ff @(posedge clk) begin
			if (en[k]) begin
				bright_s[k]  <= bright_s[k-1];
				neg_s[k]     <= neg_s[k-1];
				sec_s[k]     <= sec_s[k-1];
				sat_den_s[k] <= sat_den_s[k-1];
				hue_den_s[k] <= hue_den_s[k-1];
				sat_rem_s[k] <= sat_rem_c;
				hue_rem_s[k] <= hue_rem_c;
				sat_low_s[k] <= {sat_low_s[k-1][LOW_W-SB-1:0], {SB{1'b0}}};
				hue_low_s[k] <= {hue_low_s[k-1][LOW_W-SB-1:0], {SB{1'b0}}};
				sat_quo_s[k] <= {sat_quo_s[k-1][rgbhsv_pkg::QUO_W-SB-1:0], sat_q_c};
				hue_quo_s[k] <= {hue_quo_s[k-1][rgbhsv_pkg::QUO_W-SB-1:0], hue_q_c};
			end
		end
	end

	// ---------------- stage 7: hue fix-up ----------------
	always_comb begin
		logic signed [rgbhsv_pkg::HUE_CALC_W-1:0] offs;
		logic signed [rgbhsv_pkg::HUE_CALC_W-1:0] q;
		case (sec_s[S_DIVN])
			rgbhsv_pkg::SEC_GREEN: offs = rgbhsv_pkg::HUE_GREEN_OFFSET;
			rgbhsv_pkg::SEC_BLUE:  offs = rgbhsv_pkg::HUE_BLUE_OFFSET;
			default:               offs = '0;
		endcase
		q = signed'(hue_quo_s[S_DIVN]);
		// floor toward minus infinity for a negative numerator
		if (neg_s[S_DIVN]) begin
			hue_c = offs - q - ((hue_rem_s[S_DIVN] != '0) ? 16'sd1 : 16'sd0);
		end else begin
			hue_c = offs + q;
		end
		if (hue_c < 0) begin
			hue_c = hue_c + rgbhsv_pkg::HUE_FULL_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_OUT]) begin
			hue_s7    <= hue_c[rgbhsv_pkg::HUE_W-1:0];
			sat_s7    <= sat_quo_s[S_DIVN];
			bright_s7 <= bright_s[S_DIVN];
		end
	end

	assign hsv.valid      = valid_s[S_OUT];
	assign hsv.hue        = hue_s7;
	assign hsv.saturation = sat_s7;
	assign hsv.brightness = bright_s7;

`ifndef NO_ASSERTIONS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> valid_s[1])
		else $error("accepted pixel did not enter stage 1");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> hsv.hue < 15'd23040)
		else $error("hue out of range");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.saturation == '0 |-> hsv.hue == '0)
		else $error("zero saturation with nonzero hue");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[S_DIVN] |-> sat_rem_s[S_DIVN] < sat_den_s[S_DIVN]
			&& hue_rem_s[S_DIVN] < hue_den_s[S_DIVN])
		else $error("division remainder not below divisor");
`endif

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_to_hsv_converter. A directed set of pixels
// (black, grey, primaries, tied maxima, wrapped hue, one-step differences)
// is followed by random pixels of several kinds. Both channels idle at
// random. Every result is compared field by field with an in-bench HSV
// model, in request order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CH_W          = rgbhsv_pkg::CH_W;
	localparam int HUE_W         = rgbhsv_pkg::HUE_W;
	localparam int SAT_W         = rgbhsv_pkg::SAT_W;
	localparam int SIXTY_DEG     = 3840;
	localparam int GREEN_DEG     = 7680;
	localparam int BLUE_DEG      = 15360;
	localparam int TURN_DEG      = 23040;
	localparam int SAT_FULL      = 65535;
	localparam int RANDOM_PIXELS = 1650;
	localparam int RESET_CYCLES  = 11;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [CH_W-1:0]  brightness;
	} hsv_t;

	logic clk;
	logic arst_n = 1'b0;

	logic            px_valid = 1'b0;
	logic [CH_W-1:0] px_red   = '0;
	logic [CH_W-1:0] px_green = '0;
	logic [CH_W-1:0] px_blue  = '0;
	logic            res_ready = 1'b0;

	rgbhsv_pix_if pix_ch ();
	rgbhsv_hsv_if hsv_ch ();

	assign pix_ch.valid = px_valid;
	assign pix_ch.red   = px_red;
	assign pix_ch.green = px_green;
	assign pix_ch.blue  = px_blue;
	assign hsv_ch.ready = res_ready;

	rgb_to_hsv_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_ch),
		.hsv    (hsv_ch)
	);

	pixel_t pixel_queue[$];
	hsv_t   expected_hsv[$];

	logic   pix_fire = 1'b0;
	logic   hsv_fire = 1'b0;
	int     pix_gap = 0;
	int     pix_quiet = 0;
	int     hsv_stall = 0;
	int     hsv_quiet = 0;
	int     pixels_sent = 0;
	int     results_checked = 0;
	int     directed_count = 0;
	int     mismatches = 0;
	int     cycle_count = 0;
	pixel_t next_px;
	hsv_t   got_hsv;
	hsv_t   want_hsv;
	hsv_t   model_hsv;

	function automatic int floor_div(int num, int den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic hsv_t hsv_of_pixel(pixel_t px);
		int                  r;
		int                  g;
		int                  b;
		int                  hi;
		int                  lo;
		int                  span;
		int                  h;
		rgbhsv_pkg::sector_t sector;
		hsv_t                res;
		r = px.red;
		g = px.green;
		b = px.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		span = hi - lo;
		if (r == hi)
			sector = rgbhsv_pkg::SEC_RED;
		else if (g == hi)
			sector = rgbhsv_pkg::SEC_GREEN;
		else
			sector = rgbhsv_pkg::SEC_BLUE;
		h = 0;
		res.saturation = '0;
		if (hi != 0) begin
			res.saturation = SAT_W'(span * SAT_FULL / hi);
			if (span != 0) begin
				case (sector)
					rgbhsv_pkg::SEC_RED:
						h = floor_div(SIXTY_DEG * (g - b), span);
					rgbhsv_pkg::SEC_GREEN:
						h = GREEN_DEG + floor_div(SIXTY_DEG * (b - r), span);
					default:
						h = BLUE_DEG + floor_div(SIXTY_DEG * (r - g), span);
				endcase
				if (h < 0)
					h += TURN_DEG;
			end
		end
		res.hue = HUE_W'(h);
		res.brightness = CH_W'(hi);
		return res;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int     base;
		int     lo;
		px.red   = CH_W'($urandom_range(0, 255));
		px.green = CH_W'($urandom_range(0, 255));
		px.blue  = CH_W'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			5: begin
				base = $urandom_range(0, 255);
				px = '{CH_W'(base), CH_W'(base), CH_W'(base)};
			end
			6: begin
				base = $urandom_range(2, 255);
				px.red   = CH_W'(base - $urandom_range(0, 2));
				px.green = CH_W'(base - $urandom_range(0, 2));
				px.blue  = CH_W'(base - $urandom_range(0, 2));
			end
			7: begin
				base = $urandom_range(0, 255);
				lo = $urandom_range(0, base);
				case ($urandom_range(0, 2))
					0: px = '{CH_W'(base), CH_W'(base), CH_W'(lo)};
					1: px = '{CH_W'(base), CH_W'(lo), CH_W'(base)};
					default: px = '{CH_W'(lo), CH_W'(base), CH_W'(base)};
				endcase
			end
			8: begin
				if ($urandom_range(0, 2) == 0) px.red = '0;
				else if ($urandom_range(0, 1) == 0) px.red = '1;
				if ($urandom_range(0, 2) == 0) px.green = '0;
				else if ($urandom_range(0, 1) == 0) px.green = '1;
				if ($urandom_range(0, 2) == 0) px.blue = '0;
				else if ($urandom_range(0, 1) == 0) px.blue = '1;
			end
			9: begin
				px.red   = CH_W'($urandom_range(0, 3));
				px.green = CH_W'($urandom_range(0, 3));
				px.blue  = CH_W'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return px;
	endfunction

	function automatic int idle_draw(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	task automatic add_pixel(int r, int g, int b);
		pixel_t px;
		px = '{CH_W'(r), CH_W'(g), CH_W'(b)};
		pixel_queue.insert(pixel_queue.size(), px);
		directed_count++;
	endtask

	task automatic report_mismatch(string what, hsv_t want, hsv_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
				$realtime, what, want.hue, want.saturation, want.brightness,
				got.hue, got.saturation, got.brightness);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pixel request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pix_fire || !px_valid) begin
				if (pix_gap > 0) begin
					pix_gap--;
					px_valid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					next_px = pixel_queue.pop_front();
					px_valid <= 1'b1;
					px_red   <= next_px.red;
					px_green <= next_px.green;
					px_blue  <= next_px.blue;
					pix_gap = idle_draw(pix_quiet);
				end else begin
					px_valid <= 1'b0;
				end
			end
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (hsv_fire)
				hsv_stall = idle_draw(hsv_quiet);
			if (hsv_stall > 0) begin
				hsv_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		pix_fire = arst_n && pix_ch.valid && pix_ch.ready;
		hsv_fire = arst_n && hsv_ch.valid && hsv_ch.ready;
		if (hsv_fire) begin
			got_hsv = '{hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness};
			if (expected_hsv.size() == 0) begin
				report_mismatch("unexpected result", '0, got_hsv);
			end else begin
				want_hsv = expected_hsv.pop_front();
				results_checked++;
				if (got_hsv.hue !== want_hsv.hue
						|| got_hsv.saturation !== want_hsv.saturation
						|| got_hsv.brightness !== want_hsv.brightness)
					report_mismatch("wrong result", want_hsv, got_hsv);
			end
		end
		if (pix_fire) begin
			model_hsv = hsv_of_pixel('{pix_ch.red, pix_ch.green, pix_ch.blue});
			expected_hsv.insert(expected_hsv.size(), model_hsv);
			pixels_sent++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_hsv.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		// black, grey, white
		add_pixel(0, 0, 0);
		add_pixel(1, 1, 1);
		add_pixel(128, 128, 128);
		add_pixel(255, 255, 255);
		// primaries
		add_pixel(255, 0, 0);
		add_pixel(0, 255, 0);
		add_pixel(0, 0, 255);
		add_pixel(1, 0, 0);
		add_pixel(0, 1, 0);
		add_pixel(0, 0, 1);
		// tied maxima
		add_pixel(255, 255, 0);
		add_pixel(255, 0, 255);
		add_pixel(0, 255, 255);
		add_pixel(1, 0, 1);
		// negative hue wrap in red sector
		add_pixel(255, 0, 1);
		add_pixel(200, 10, 254 - 55);
		// green and blue sectors, both signs
		add_pixel(200, 255, 0);
		add_pixel(0, 255, 200);
		add_pixel(0, 100, 255);
		add_pixel(100, 0, 255);
		// spans of one and two steps
		add_pixel(255, 254, 254);
		add_pixel(254, 255, 255);
		add_pixel(17, 16, 18);
		repeat (RANDOM_PIXELS) pixel_queue.insert(pixel_queue.size(), random_pixel());

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixel_queue.size() > 0 || px_valid || expected_hsv.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels (%0d directed, %0d random) with random gaps and stalls",
			pixels_sent, directed_count, pixels_sent - directed_count);
		$display("Checked %0d HSV results, %0d mismatching", results_checked, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[rgb_to_hsv_converter.f]
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_pix_if.sv
rtl/rgbhsv_hsv_if.sv
rtl/rgbhsv_div_step.sv
rtl/rgb_to_hsv_converter.sv
bench/testbench.sv
